// ===== hdl/ed_exec_pkg.sv =====
// ---------------------------------------------------------------------------
// ed_exec_pkg
// Types, operation codes and flag helpers for the ED-group execute unit.
// ---------------------------------------------------------------------------
package ed_exec_pkg;

	typedef enum logic [4:0] {
		OP_ADC16  = 5'd0,  OP_SBC16 = 5'd1,  OP_NEG  = 5'd2,  OP_RRD  = 5'd3,
		OP_RLD    = 5'd4,  OP_INF   = 5'd5,  OP_LDAIR = 5'd6,
		OP_LDI    = 5'd7,  OP_CPI   = 5'd8,  OP_INI  = 5'd9,  OP_OUTI = 5'd10,
		OP_LDD    = 5'd11, OP_CPD   = 5'd12, OP_IND  = 5'd13, OP_OUTD = 5'd14,
		OP_LDIR   = 5'd15, OP_CPIR  = 5'd16, OP_INIR = 5'd17, OP_OTIR = 5'd18,
		OP_LDDR   = 5'd19, OP_CPDR  = 5'd20, OP_INDR = 5'd21, OP_OTDR = 5'd22
	} op_t;

	localparam logic [1:0] KIND_LD  = 2'd0;
	localparam logic [1:0] KIND_CP  = 2'd1;
	localparam logic [1:0] KIND_IN  = 2'd2;
	localparam logic [1:0] KIND_OUT = 2'd3;

	localparam logic [4:0] T_BLOCK  = 5'd16;
	localparam logic [4:0] T_REPEAT = 5'd21;

	typedef struct packed {
		logic [4:0]  operation;
		logic [7:0]  reg_a;
		logic [7:0]  reg_f;
		logic [15:0] reg_bc;
		logic [15:0] reg_de;
		logic [15:0] reg_hl;
		logic [15:0] operand_word;
		logic [7:0]  data_byte;
		logic        iff2;
		logic [7:0]  special_byte;
		logic [15:0] memptr;
		logic [15:0] pc;
	} ed_in_t;

	typedef struct packed {
		logic [7:0]  new_a;
		logic [7:0]  new_f;
		logic [15:0] new_bc;
		logic [15:0] new_de;
		logic [15:0] new_hl;
		logic [15:0] new_memptr;
		logic [15:0] new_pc;
		logic [7:0]  write_byte;
		logic        again;
		logic [4:0]  tstates;
	} ed_out_t;

	function automatic logic [7:0] szxy8(input logic [7:0] v);
		szxy8 = (v & 8'hA8) | ((v == 8'h00) ? 8'h40 : 8'h00);
	endfunction

	function automatic logic par_even(input logic [7:0] v);
		par_even = ~(^v);
	endfunction

endpackage

// ===== hdl/ed_exec_alu.sv =====
// ---------------------------------------------------------------------------
// ed_exec_alu
// Combinational execute logic for one ED-group instruction.
// ---------------------------------------------------------------------------
module ed_exec_alu (
	input  ed_exec_pkg::ed_in_t  din,
	output ed_exec_pkg::ed_out_t dout
);
	import ed_exec_pkg::*;

	logic [16:0] add17, sub17;
	logic [12:0] addh, subh;
	logic [15:0] res16;
	logic [7:0]  neg8;
	logic [2:0]  base;
	logic [1:0]  kind;
	logic        down, rep, cont, c;
	logic [15:0] step, hl_s, de_s, bc_m1, bc_io, pc_m2;
	logic [7:0]  nld, rcp, ncp, nb, cl_s;
	logic        hcp;
	logic [8:0]  k;

	always_comb begin
		c     = din.reg_f[0];
		add17 = {1'b0, din.reg_hl} + {1'b0, din.operand_word} + {16'd0, c};
		sub17 = {1'b0, din.reg_hl} - {1'b0, din.operand_word} - {16'd0, c};
		addh  = {1'b0, din.reg_hl[11:0]} + {1'b0, din.operand_word[11:0]} + {12'd0, c};
		subh  = {1'b0, din.reg_hl[11:0]} - {1'b0, din.operand_word[11:0]} - {12'd0, c};
		neg8  = 8'h00 - din.reg_a;
		base  = 3'(din.operation - OP_LDI);
		kind  = base[1:0];
		down  = base[2];
		rep   = din.operation >= OP_LDIR;
		step  = down ? 16'hFFFF : 16'h0001;
		hl_s  = din.reg_hl + step;
		de_s  = din.reg_de + step;
		bc_m1 = din.reg_bc - 16'd1;
		nb    = din.reg_bc[15:8] - 8'd1;
		bc_io = {nb, din.reg_bc[7:0]};
		pc_m2 = din.pc - 16'd2;
		nld   = din.data_byte + din.reg_a;
		rcp   = din.reg_a - din.data_byte;
		hcp   = din.reg_a[3:0] < din.data_byte[3:0];
		ncp   = rcp - {7'd0, hcp};
		cl_s  = din.reg_bc[7:0] + step[7:0];
		k     = {1'b0, din.data_byte} +
			{1'b0, (kind == KIND_IN) ? cl_s : hl_s[7:0]};
		res16 = 16'd0;
		cont  = 1'b0;

		dout.new_a      = din.reg_a;
		dout.new_f      = din.reg_f;
		dout.new_bc     = din.reg_bc;
		dout.new_de     = din.reg_de;
		dout.new_hl     = din.reg_hl;
		dout.new_memptr = din.memptr;
		dout.new_pc     = din.pc;
		dout.write_byte = 8'h00;
		dout.again      = 1'b0;
		dout.tstates    = 5'd8;

		case (din.operation)
			OP_ADC16, OP_SBC16: begin
				res16 = (din.operation == OP_ADC16) ? add17[15:0] : sub17[15:0];
				if (din.operation == OP_ADC16) begin
					dout.new_f = {res16[15], res16 == 16'd0, res16[13], addh[12],
						res16[11],
						~(din.reg_hl[15] ^ din.operand_word[15]) &
						(din.reg_hl[15] ^ res16[15]), 1'b0, add17[16]};
				end else begin
					dout.new_f = {res16[15], res16 == 16'd0, res16[13], subh[12],
						res16[11],
						(din.reg_hl[15] ^ din.operand_word[15]) &
						(din.reg_hl[15] ^ res16[15]), 1'b1, sub17[16]};
				end
				dout.new_memptr = din.reg_hl + 16'd1;
				dout.new_hl     = res16;
				dout.tstates    = 5'd15;
			end
			OP_NEG: begin
				dout.new_f = szxy8(neg8) | {3'd0, din.reg_a[3:0] != 4'd0, 1'b0,
					din.reg_a == 8'h80, 1'b1, din.reg_a != 8'd0};
				dout.new_a = neg8;
			end
			OP_RRD, OP_RLD: begin
				if (din.operation == OP_RRD) begin
					dout.new_a      = {din.reg_a[7:4], din.data_byte[3:0]};
					dout.write_byte = {din.reg_a[3:0], din.data_byte[7:4]};
				end else begin
					dout.new_a      = {din.reg_a[7:4], din.data_byte[7:4]};
					dout.write_byte = {din.data_byte[3:0], din.reg_a[3:0]};
				end
				dout.new_f = szxy8(dout.new_a) |
					{5'd0, par_even(dout.new_a), 1'b0, c};
				dout.new_memptr = din.reg_hl + 16'd1;
				dout.tstates    = 5'd18;
			end
			OP_INF: begin
				dout.new_f = szxy8(din.data_byte) |
					{5'd0, par_even(din.data_byte), 1'b0, c};
				dout.new_memptr = din.reg_bc + 16'd1;
				dout.tstates    = 5'd12;
			end
			OP_LDAIR: begin
				dout.new_a   = din.special_byte;
				dout.new_f   = szxy8(din.special_byte) | {5'd0, din.iff2, 1'b0, c};
				dout.tstates = 5'd9;
			end
			OP_LDI, OP_CPI, OP_INI, OP_OUTI, OP_LDD, OP_CPD, OP_IND, OP_OUTD,
			OP_LDIR, OP_CPIR, OP_INIR, OP_OTIR, OP_LDDR, OP_CPDR, OP_INDR,
			OP_OTDR: begin
				dout.new_hl = hl_s;
				case (kind)
					KIND_LD: begin
						dout.new_de     = de_s;
						dout.new_bc     = bc_m1;
						dout.new_f      = {din.reg_f[7:6], nld[1], 1'b0, nld[3],
							bc_m1 != 16'd0, 1'b0, din.reg_f[0]};
						dout.write_byte = din.data_byte;
						cont            = bc_m1 != 16'd0;
					end
					KIND_CP: begin
						dout.new_bc     = bc_m1;
						dout.new_f      = {rcp[7], rcp == 8'd0, ncp[1], hcp, ncp[3],
							bc_m1 != 16'd0, 1'b1, c};
						dout.new_memptr = din.memptr + step;
						cont            = (bc_m1 != 16'd0) && (rcp != 8'd0);
					end
					default: begin
						dout.new_bc     = bc_io;
						dout.new_memptr = (kind == KIND_IN) ? din.reg_bc + step :
							bc_io + step;
						dout.write_byte = din.data_byte;
						dout.new_f      = szxy8(nb) | {3'd0, k[8], 1'b0,
							par_even({5'd0, k[2:0]} ^ nb), din.data_byte[7], k[8]};
						cont            = nb != 8'd0;
					end
				endcase
				dout.tstates = T_BLOCK;
				if (rep && cont) begin
					dout.new_pc  = pc_m2;
					dout.again   = 1'b1;
					dout.tstates = T_REPEAT;
					if (!kind[1]) dout.new_memptr = pc_m2 + 16'd1;
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== hdl/ed_group_execute_unit.sv =====
// Pipeline: a command taken at a clock edge passes the input register, then
// the result register, and its result is then strobed on done.
// Throughput: one command per cycle; busy is held low.
// Reset: arst_n clears the strobes; the payload registers are not reset.
// The receiver cannot stall: each result is valid for a single cycle.
// ---------------------------------------------------------------------------
// ed_group_execute_unit
// Execute stage for the ED-prefix instruction group: input register,
// combinational datapath, result register.
// ---------------------------------------------------------------------------
module ed_group_execute_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  ed_exec_pkg::ed_in_t  cmd,
	output logic                 done,
	output ed_exec_pkg::ed_out_t result
);
	import ed_exec_pkg::*;

	ed_in_t  cmd_s1;
	logic    vld_s1;
	ed_out_t res_c;
	ed_out_t res_s2;
	logic    vld_s2;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) cmd_s1 <= cmd;
		if (vld_s1) res_s2 <= res_c;
	end

	ed_exec_alu u_alu (
		.din  (cmd_s1),
		.dout (res_c)
	);

	assign done   = vld_s2;
	assign result = res_s2;

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##2 done) else $error("start without done");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!start |-> ##2 !done) else $error("done without start");
	a_tstates: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.again == (result.tstates == T_REPEAT)))
		else $error("again and tstates disagree");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for ed_group_execute_unit: a directed set of ED-group
// instructions, then random ones, with random start gaps; every strobed
// result is compared whole against an in-bench instruction model.
// ---------------------------------------------------------------------------
module tb;
	import ed_exec_pkg::*;

	localparam int WATCHDOG = 2000;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	ed_in_t  cmd = '0;
	logic    busy;
	logic    done;
	ed_out_t result;

	ed_in_t  pending_q[$];
	ed_out_t exec_q[$];
	int      errors = 0;
	int      idle_pct = 21;
	bit      stim_done = 1'b0;
	int      quiet_cycles = 0;
	// busy as seen at the last rising edge, so the pop matches acceptance
	logic    busy_q = 1'b0;

	ed_group_execute_unit uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .done(done), .result(result)
	);

	always #1 clk = ~clk;

	function automatic logic even8(input logic [7:0] v);
		even8 = ~(^v);
	endfunction

	function automatic logic [7:0] sz8(input logic [7:0] v);
		sz8 = {v[7], v == 8'h00, v[5], 1'b0, v[3], 3'b000};
	endfunction

	function automatic ed_out_t execute_instr(input ed_in_t c);
		ed_out_t     o;
		logic [16:0] sum;
		logic [15:0] res, stp;
		logic [7:0]  a, f, d, r, n, nb, cl;
		logic [8:0]  k;
		logic        cy, h, v, cont, rep, down;
		logic [2:0]  base;
		logic [1:0]  kind;
		o.new_a = c.reg_a;        o.new_f = c.reg_f;
		o.new_bc = c.reg_bc;      o.new_de = c.reg_de;
		o.new_hl = c.reg_hl;      o.new_memptr = c.memptr;
		o.new_pc = c.pc;          o.write_byte = 8'h00;
		o.again = 1'b0;           o.tstates = 5'd8;
		a = c.reg_a; f = c.reg_f; d = c.data_byte; cy = f[0];
		case (c.operation)
			OP_ADC16, OP_SBC16: begin
				if (c.operation == OP_ADC16) begin
					sum = c.reg_hl + c.operand_word + cy;
					res = sum[15:0];
					h = ({1'b0, c.reg_hl[11:0]} + c.operand_word[11:0] + cy) > 13'h0FFF;
					v = ~(c.reg_hl[15] ^ c.operand_word[15]) & (c.reg_hl[15] ^ res[15]);
					o.new_f = {res[15], res == 16'h0, res[13], h, res[11], v, 1'b0, sum[16]};
				end else begin
					sum = {1'b0, c.reg_hl} - c.operand_word - cy;
					res = sum[15:0];
					h = {1'b0, c.reg_hl[11:0]} < ({1'b0, c.operand_word[11:0]} + cy);
					v = (c.reg_hl[15] ^ c.operand_word[15]) & (c.reg_hl[15] ^ res[15]);
					o.new_f = {res[15], res == 16'h0, res[13], h, res[11], v, 1'b1,
						{1'b0, c.reg_hl} < ({1'b0, c.operand_word} + cy)};
				end
				o.new_memptr = c.reg_hl + 16'd1;
				o.new_hl = res;
				o.tstates = 5'd15;
			end
			OP_NEG: begin
				r = 8'h00 - a;
				o.new_f = sz8(r) | {3'b000, a[3:0] != 4'h0, 1'b0, a == 8'h80, 1'b1, a != 8'h00};
				o.new_a = r;
			end
			OP_RRD, OP_RLD: begin
				if (c.operation == OP_RRD) begin
					r = {a[7:4], d[3:0]};
					o.write_byte = {a[3:0], d[7:4]};
				end else begin
					r = {a[7:4], d[7:4]};
					o.write_byte = {d[3:0], a[3:0]};
				end
				o.new_a = r;
				o.new_f = sz8(r) | {5'b0, even8(r), 1'b0, cy};
				o.new_memptr = c.reg_hl + 16'd1;
				o.tstates = 5'd18;
			end
			OP_INF: begin
				o.new_f = sz8(d) | {5'b0, even8(d), 1'b0, cy};
				o.new_memptr = c.reg_bc + 16'd1;
				o.tstates = 5'd12;
			end
			OP_LDAIR: begin
				o.new_a = c.special_byte;
				o.new_f = sz8(c.special_byte) | {5'b0, c.iff2, 1'b0, cy};
				o.tstates = 5'd9;
			end
			default: if (c.operation <= OP_OTDR) begin
				base = 3'(c.operation - OP_LDI);
				kind = base[1:0];
				down = base[2];
				rep = c.operation >= OP_LDIR;
				stp = down ? 16'hFFFF : 16'h0001;
				cl = c.reg_bc[7:0];
				o.new_hl = c.reg_hl + stp;
				cont = 1'b0;
				case (kind)
					KIND_LD: begin
						n = d + a;
						o.new_de = c.reg_de + stp;
						o.new_bc = c.reg_bc - 16'd1;
						o.new_f = (f & 8'hC1) | {2'b00, n[1], 1'b0, n[3], o.new_bc != 16'h0, 2'b00};
						o.write_byte = d;
						cont = o.new_bc != 16'h0;
					end
					KIND_CP: begin
						r = a - d;
						h = a[3:0] < d[3:0];
						n = r - h;
						o.new_bc = c.reg_bc - 16'd1;
						o.new_f = {r[7], r == 8'h00, n[1], h, n[3], o.new_bc != 16'h0, 1'b1, cy};
						o.new_memptr = c.memptr + stp;
						cont = (o.new_bc != 16'h0) && (r != 8'h00);
					end
					default: begin
						nb = c.reg_bc[15:8] - 8'd1;
						o.new_bc = {nb, cl};
						if (kind == KIND_IN) begin
							k = d + 9'(8'(cl + stp[7:0]));
							o.new_memptr = c.reg_bc + stp;
						end else begin
							k = d + o.new_hl[7:0];
							o.new_memptr = {nb, cl} + stp;
						end
						o.write_byte = d;
						o.new_f = sz8(nb) | {3'b000, k[8], 1'b0,
							even8({5'b0, k[2:0]} ^ nb), d[7], k[8]};
						cont = nb != 8'h00;
					end
				endcase
				o.tstates = T_BLOCK;
				if (rep && cont) begin
					o.new_pc = c.pc - 16'd2;
					o.again = 1'b1;
					o.tstates = T_REPEAT;
					if (kind == KIND_LD || kind == KIND_CP)
						o.new_memptr = o.new_pc + 16'd1;
				end
			end
		endcase
		return o;
	endfunction

	function automatic ed_in_t rand_cmd(input logic [4:0] op);
		ed_in_t c;
		c.operation = op;
		c.reg_a = 8'($urandom);          c.reg_f = 8'($urandom);
		c.reg_bc = 16'($urandom);        c.reg_de = 16'($urandom);
		c.reg_hl = 16'($urandom);        c.operand_word = 16'($urandom);
		c.data_byte = 8'($urandom);      c.iff2 = 1'($urandom);
		c.special_byte = 8'($urandom);   c.memptr = 16'($urandom);
		c.pc = 16'($urandom);
		case ($urandom_range(0, 7))
			0: c.reg_bc = 16'($urandom_range(0, 2));
			1: c.reg_bc[15:8] = 8'($urandom_range(0, 2));
			2: c.data_byte = c.reg_a;
			3: c.reg_a = 8'($urandom_range(0, 1) ? 8'h80 : 8'h00);
			4: c.operand_word = 16'h0000 - c.reg_hl - 16'($urandom_range(0, 1));
			default: ;
		endcase
		return c;
	endfunction

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (start && !busy_q)
				void'(pending_q.pop_front());
			if (pending_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
				start <= 1'b1;
				cmd <= pending_q[0];
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		busy_q <= busy;
		if (arst_n && start && !busy)
			exec_q.push_back(execute_instr(cmd));
	end

	// monitor
	always @(posedge clk) begin
		ed_out_t e;
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (done) begin
				if (exec_q.size() == 0) begin
					$display("%0t: unexpected result %h", $time, result);
					errors++;
				end else begin
					e = exec_q.pop_front();
					if (result !== e) begin
						$display("%0t: mismatch expected %h actual %h", $time, e, result);
						if (result.new_f !== e.new_f)
							$display("  new_f expected %h actual %h", e.new_f, result.new_f);
						errors++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (quiet_cycles >= WATCHDOG) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		ed_in_t c;
		c = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// directed: every code incl. unknown ones, extremes, end of repeat
		for (int op = 0; op < 32; op++) begin
			c = rand_cmd(5'(op));
			if (op % 2 == 0) c = ~c;
			c.operation = 5'(op);
			if (op >= OP_LDIR && op <= OP_OTDR)
				c.reg_bc = (op % 2 == 0) ? 16'h0001 : 16'h0105;
			pending_q.push_back(c);
		end
		c = '0; c.operation = OP_NEG; c.reg_a = 8'h80; pending_q.push_back(c);
		c = '1; c.operation = OP_ADC16; pending_q.push_back(c);
		c = '0; c.operation = OP_CPIR; c.reg_bc = 16'h0010; pending_q.push_back(c);
		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 21 : (ph == 1) ? 61 : 0;
			for (int i = 0; i < 500; i++)
				pending_q.push_back(rand_cmd($urandom_range(0, 9) == 0 ?
					5'($urandom_range(23, 31)) : 5'($urandom_range(0, 22))));
			while (pending_q.size() > 0) @(posedge clk);
		end
		while (exec_q.size() > 0) @(posedge clk);
		repeat (5) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/ed_exec_pkg.sv
hdl/ed_exec_alu.sv
hdl/ed_group_execute_unit.sv
tb/sv/tb.sv
